// ----- design/assert_macros.svh -----
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge while the block is out of reset.
`define QAU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define QAU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/qau_pkg.sv -----
// Shared constants and helpers of the quaternion arithmetic unit.
package qau_pkg;

  localparam int FRAC_BITS_DEF  = 14;
  localparam int COMP_WIDTH_DEF = 16;

  localparam int MODE_W     = 2;
  localparam int NORM_W     = 19;
  localparam int OUT_USER_W = 2;
  localparam int NORM_MAX   = 524287;

  localparam logic [MODE_W-1:0] MODE_MUL   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUB   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SCALE = 2'd3;

  // Accumulator width: holds four full products and the rounding constant.
  function automatic int acc_width(input int comp_w, input int frac_w);
    int a;
    a = 2 * comp_w + 2;
    if (frac_w + 2 > a) begin
      a = frac_w + 2;
    end
    return a;
  endfunction

endpackage

// ----- design/qau_lane.sv -----
// One result component: four products summed, rounded and saturated, or a sum/difference.
module qau_lane #(
  parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF,
  parameter int COMP_WIDTH = qau_pkg::COMP_WIDTH_DEF
) (
  input  logic [qau_pkg::MODE_W-1:0] mode,
  input  logic signed [COMP_WIDTH-1:0] mul_a [4],
  input  logic signed [COMP_WIDTH-1:0] mul_b [4],
  input  logic [3:0]                   neg,
  input  logic signed [COMP_WIDTH-1:0] add_a,
  input  logic signed [COMP_WIDTH-1:0] add_b,
  output logic signed [COMP_WIDTH-1:0] res,
  output logic                         sat
);

  localparam int ACC_W = qau_pkg::acc_width(COMP_WIDTH, FRAC_BITS);
  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-COMP_WIDTH+1){1'b0}}, {(COMP_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [2*COMP_WIDTH-1:0] prod [4];
  logic signed [ACC_W-1:0]        term [4];
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        rnd;
  logic signed [ACC_W-1:0]        val;
  logic signed [COMP_WIDTH:0]     addsub;

  always_comb begin
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      prod[i] = mul_a[i] * mul_b[i];
      term[i] = neg[i] ? -ACC_W'(prod[i]) : ACC_W'(prod[i]);
      acc     = acc + term[i];
    end
    // Round half up once on the exact sum, then floor by the fraction width.
    rnd = (acc + HALF) >>> FRAC_BITS;
  end

  always_comb begin
    if (mode == qau_pkg::MODE_SUB) begin
      addsub = (COMP_WIDTH+1)'(add_a) - (COMP_WIDTH+1)'(add_b);
    end else begin
      addsub = (COMP_WIDTH+1)'(add_a) + (COMP_WIDTH+1)'(add_b);
    end
    case (mode)
      qau_pkg::MODE_ADD,
      qau_pkg::MODE_SUB: val = ACC_W'(addsub);
      default:           val = rnd;
    endcase
  end

  always_comb begin
    sat = 1'b0;
    if (val > SAT_HI) begin
      res = SAT_HI[COMP_WIDTH-1:0];
      sat = 1'b1;
    end else if (val < SAT_LO) begin
      res = SAT_LO[COMP_WIDTH-1:0];
      sat = 1'b1;
    end else begin
      res = val[COMP_WIDTH-1:0];
    end
  end

endmodule

// ----- design/qau_datapath.sv -----
// Operand routing for the four lanes, squared norm of A and the equality flag.
module qau_datapath #(
  parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF,
  parameter int COMP_WIDTH = qau_pkg::COMP_WIDTH_DEF
) (
  input  logic [qau_pkg::MODE_W-1:0]   mode,
  input  logic signed [COMP_WIDTH-1:0] a [4],
  input  logic signed [COMP_WIDTH-1:0] b [4],
  input  logic signed [COMP_WIDTH-1:0] scalar,
  output logic signed [COMP_WIDTH-1:0] r [4],
  output logic [qau_pkg::NORM_W-1:0]   norm_sq,
  output logic                         equal,
  output logic                         saturated
);

  localparam int ACC_W = qau_pkg::acc_width(COMP_WIDTH, FRAC_BITS);
  localparam logic [ACC_W-1:0] HALF =
    {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic [ACC_W-1:0] NORM_LIM = ACC_W'(qau_pkg::NORM_MAX);

  // Component order everywhere: 0 x, 1 y, 2 z, 3 w.
  logic signed [COMP_WIDTH-1:0] ma [4][4];
  logic signed [COMP_WIDTH-1:0] mb [4][4];
  logic [3:0]                   ng [4];
  logic [3:0]                   lane_sat;

  logic signed [2*COMP_WIDTH-1:0] sq [4];
  logic [ACC_W-1:0]               nacc;
  logic [ACC_W-1:0]               nrnd;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      ng[l] = 4'b0000;
      for (int t = 0; t < 4; t++) begin
        ma[l][t] = '0;
        mb[l][t] = '0;
      end
    end
    case (mode)
      qau_pkg::MODE_MUL: begin
        // Hamilton product; the last term of x, y, z and the last three of w subtract.
        ma[0] = '{a[3], a[0], a[1], a[2]};  mb[0] = '{b[0], b[3], b[2], b[1]};
        ma[1] = '{a[3], a[1], a[2], a[0]};  mb[1] = '{b[1], b[3], b[0], b[2]};
        ma[2] = '{a[3], a[2], a[0], a[1]};  mb[2] = '{b[2], b[3], b[1], b[0]};
        ma[3] = '{a[3], a[0], a[1], a[2]};  mb[3] = '{b[3], b[0], b[1], b[2]};
        ng[0] = 4'b1000;
        ng[1] = 4'b1000;
        ng[2] = 4'b1000;
        ng[3] = 4'b1110;
      end
      qau_pkg::MODE_SCALE: begin
        for (int l = 0; l < 4; l++) begin
          ma[l][0] = scalar;
          mb[l][0] = a[l];
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    qau_lane #(
      .FRAC_BITS (FRAC_BITS),
      .COMP_WIDTH(COMP_WIDTH)
    ) u_lane (
      .mode (mode),
      .mul_a(ma[g]),
      .mul_b(mb[g]),
      .neg  (ng[g]),
      .add_a(a[g]),
      .add_b(b[g]),
      .res  (r[g]),
      .sat  (lane_sat[g])
    );
  end

  assign saturated = |lane_sat;

  always_comb begin
    nacc = '0;
    for (int i = 0; i < 4; i++) begin
      sq[i] = a[i] * a[i];
      nacc  = nacc + ACC_W'($unsigned(sq[i]));
    end
    nrnd = (nacc + HALF) >> FRAC_BITS;
    if (nrnd > NORM_LIM) begin
      norm_sq = '1;
    end else begin
      norm_sq = nrnd[qau_pkg::NORM_W-1:0];
    end
  end

  assign equal = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]) && (a[3] == b[3]);

endmodule

// ----- design/quaternion_arithmetic_unit_core.sv -----
// Top level of the quaternion arithmetic unit: stream ports, input and result registers.
// Accepted requests enter the input register; their results then enter the result register on out_tdata.
// Throughput: one request per cycle while out_tready allows; the result register and the input register
// each advance whenever the stage after them is empty or being emptied.
// One pass of combinational logic (twenty multipliers, lane sums, saturation) sits between them.
// Reset (rst_n low, synchronous) empties both stages; payload registers are not reset.
module quaternion_arithmetic_unit_core #(
  parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF,
  parameter int COMP_WIDTH = qau_pkg::COMP_WIDTH_DEF,
  localparam int IN_DATA_W  = ((9 * COMP_WIDTH + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((4 * COMP_WIDTH + qau_pkg::NORM_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar, zero padding
  input  logic [IN_DATA_W-1:0]           in_tdata,
  // mode
  input  logic [qau_pkg::MODE_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // r_x, r_y, r_z, r_w, norm_sq, zero padding
  output logic [OUT_DATA_W-1:0]          out_tdata,
  // equal, saturated
  output logic [qau_pkg::OUT_USER_W-1:0] out_tuser
);

  logic                         s1_valid_r;
  logic [qau_pkg::MODE_W-1:0]   mode_r;
  logic signed [COMP_WIDTH-1:0] a_r [4];
  logic signed [COMP_WIDTH-1:0] b_r [4];
  logic signed [COMP_WIDTH-1:0] scalar_r;

  logic                         s2_valid_r;
  logic signed [COMP_WIDTH-1:0] res_r [4];
  logic [qau_pkg::NORM_W-1:0]   norm_r;
  logic                         equal_r;
  logic                         sat_r;

  logic                         s2_load;
  logic                         s1_load;

  logic signed [COMP_WIDTH-1:0] res_c [4];
  logic [qau_pkg::NORM_W-1:0]   norm_c;
  logic                         equal_c;
  logic                         sat_c;

  assign s2_load   = !s2_valid_r || out_tready;
  assign s1_load   = !s1_valid_r || s2_load;
  assign in_tready = s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_tvalid;
    end
    if (s1_load && in_tvalid) begin
      mode_r   <= in_tuser;
      scalar_r <= in_tdata[8*COMP_WIDTH +: COMP_WIDTH];
      for (int i = 0; i < 4; i++) begin
        a_r[i] <= in_tdata[i*COMP_WIDTH +: COMP_WIDTH];
        b_r[i] <= in_tdata[(i+4)*COMP_WIDTH +: COMP_WIDTH];
      end
    end
  end

  qau_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .COMP_WIDTH(COMP_WIDTH)
  ) u_datapath (
    .mode     (mode_r),
    .a        (a_r),
    .b        (b_r),
    .scalar   (scalar_r),
    .r        (res_c),
    .norm_sq  (norm_c),
    .equal    (equal_c),
    .saturated(sat_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_load) begin
      s2_valid_r <= s1_valid_r;
    end
    if (s2_load && s1_valid_r) begin
      res_r   <= res_c;
      norm_r  <= norm_c;
      equal_r <= equal_c;
      sat_r   <= sat_c;
    end
  end

  assign out_tvalid = s2_valid_r;
  assign out_tdata  = OUT_DATA_W'({norm_r, res_r[3], res_r[2], res_r[1], res_r[0]});
  assign out_tuser  = {sat_r, equal_r};

endmodule

// ----- design/qau_checker.sv -----
// Port-level checks of the quaternion arithmetic unit, bound to its top level.
`include "assert_macros.svh"

module qau_checker #(
  parameter int COMP_WIDTH = qau_pkg::COMP_WIDTH_DEF,
  localparam int OUT_DATA_W = ((4 * COMP_WIDTH + qau_pkg::NORM_W + 7) / 8) * 8
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [OUT_DATA_W-1:0]          out_tdata,
  input logic [qau_pkg::OUT_USER_W-1:0] out_tuser
);

  localparam logic [COMP_WIDTH-1:0] C_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
  localparam logic [COMP_WIDTH-1:0] C_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

  logic [3:0] at_limit;
  logic       in_req;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      at_limit[i] = (out_tdata[i*COMP_WIDTH +: COMP_WIDTH] == C_MAX) ||
                    (out_tdata[i*COMP_WIDTH +: COMP_WIDTH] == C_MIN);
    end
  end

  assign in_req = in_tvalid && in_tready;

  `QAU_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `QAU_ASSERT(a_ready_when_empty, clk, rst_n, !out_tvalid |-> in_tready, "input stalled while output is empty")
  `QAU_ASSERT(a_flow_through, clk, rst_n, in_req ##1 out_tready |=> out_tvalid, "accepted request did not reach the output")
  `QAU_ASSERT(a_sat_at_limit, clk, rst_n, out_tvalid && out_tuser[1] |-> (at_limit != 4'b0000), "saturated flag without a clipped component")

endmodule

bind quaternion_arithmetic_unit_core qau_checker #(
  .COMP_WIDTH(COMP_WIDTH)
) u_qau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
